// ===== design/smas_pkg.sv =====
package smas_pkg;

	// Input opcodes.
	typedef enum logic [2:0] {
		OP_SRAM_RD = 3'd0,
		OP_SRAM_WR = 3'd1,
		OP_EE_RD   = 3'd2,
		OP_EE_WR   = 3'd3,
		OP_FLUSH   = 3'd4
	} smas_op_t;

	// Bus actions on the output stream.
	typedef enum logic [2:0] {
		ACT_DESEL_SHORT = 3'd0,
		ACT_DESEL_LONG  = 3'd1,
		ACT_SELECT      = 3'd2,
		ACT_SEND        = 3'd3,
		ACT_RECV        = 3'd4
	} smas_act_t;

	// Bus mode held between items. The write-enable mode only exists inside
	// one EEPROM write run, so it never needs to be stored.
	typedef enum logic [4:0] {
		MODE_NONE    = 5'b00001,
		MODE_SRAM_RD = 5'b00010,
		MODE_SRAM_WR = 5'b00100,
		MODE_EE_RD   = 5'b01000,
		MODE_EE_WR   = 5'b10000
	} smas_mode_t;

	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] RECV_FILL = 8'hFF;

	localparam int EE_PAGE_BYTES = 256;
	localparam int EE_PAGE_BITS  = $clog2(EE_PAGE_BYTES);

	// Slots of an action run, emitted from the lowest set slot upward.
	localparam int NUM_SLOTS = 12;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam logic [SLOT_W-1:0] SL_DESEL0 = 4'd0;
	localparam logic [SLOT_W-1:0] SL_DESEL1 = 4'd1;
	localparam logic [SLOT_W-1:0] SL_SELECT = 4'd2;
	localparam logic [SLOT_W-1:0] SL_WREN   = 4'd3;
	localparam logic [SLOT_W-1:0] SL_WDESEL = 4'd4;
	localparam logic [SLOT_W-1:0] SL_WSEL   = 4'd5;
	localparam logic [SLOT_W-1:0] SL_CMD    = 4'd6;
	localparam logic [SLOT_W-1:0] SL_ADDR2  = 4'd7;
	localparam logic [SLOT_W-1:0] SL_ADDR1  = 4'd8;
	localparam logic [SLOT_W-1:0] SL_ADDR0  = 4'd9;
	localparam logic [SLOT_W-1:0] SL_DATA   = 4'd10;
	localparam logic [SLOT_W-1:0] SL_PAGE   = 4'd11;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] slots;
		logic                 desel_long;
		logic                 device;
		logic                 receive;
		logic [7:0]           cmd;
		logic [23:0]          address;
		logic [7:0]           write_data;
	} smas_job_t;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef struct packed {
		logic not_empty;
		logic full;
	} smas_q_stat_t;

	typedef struct packed {
		logic busy;
	} smas_back_stat_t;

endpackage

// ===== design/smas_front.sv =====
module smas_front
	import smas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [2:0]  opcode,
	input  logic [23:0] address,
	input  logic [7:0]  write_data,
	output smas_job_t   job,
	output logic        push
);

	smas_mode_t  mode_q, mode_d, want;
	logic [15:0] snext_q, snext_d;
	logic [23:0] enext_q, enext_d;

	always_comb begin
		job            = '0;
		job.address    = address;
		job.write_data = write_data;
		mode_d         = mode_q;
		snext_d        = snext_q;
		enext_d        = enext_q;
		want           = MODE_NONE;
		case (opcode)
			OP_SRAM_RD, OP_SRAM_WR: begin
				want        = (opcode == OP_SRAM_RD) ? MODE_SRAM_RD : MODE_SRAM_WR;
				job.receive = (opcode == OP_SRAM_RD);
				job.cmd     = (opcode == OP_SRAM_RD) ? CMD_READ : CMD_WRITE;
				job.slots[SL_DATA] = 1'b1;
				if (!(mode_q == want && snext_q == address[15:0])) begin
					job.slots[SL_DESEL0] = 1'b1;
					job.desel_long       = (mode_q == MODE_EE_WR);
					// Same mode but a jump in address: close, then reopen.
					job.slots[SL_DESEL1] = (mode_q == want);
					job.slots[SL_SELECT] = 1'b1;
					job.slots[SL_CMD]    = 1'b1;
					job.slots[SL_ADDR1]  = 1'b1;
					job.slots[SL_ADDR0]  = 1'b1;
				end
				mode_d  = want;
				snext_d = address[15:0] + 16'd1;
			end
			OP_EE_RD: begin
				job.receive = 1'b1;
				job.cmd     = CMD_READ;
				job.device  = 1'b1;
				job.slots[SL_DATA] = 1'b1;
				if (!(mode_q == MODE_EE_RD && enext_q == address)) begin
					job.slots[SL_DESEL0] = 1'b1;
					job.desel_long       = (mode_q == MODE_EE_WR);
					job.slots[SL_DESEL1] = (mode_q == MODE_EE_RD);
					job.slots[SL_SELECT] = 1'b1;
					job.slots[SL_CMD]    = 1'b1;
					job.slots[SL_ADDR2]  = 1'b1;
					job.slots[SL_ADDR1]  = 1'b1;
					job.slots[SL_ADDR0]  = 1'b1;
				end
				mode_d  = MODE_EE_RD;
				enext_d = address + 24'd1;
			end
			OP_EE_WR: begin
				job.cmd    = CMD_WRITE;
				job.device = 1'b1;
				job.slots[SL_DATA] = 1'b1;
				if (!(mode_q == MODE_EE_WR && enext_q == address)) begin
					job.slots[SL_DESEL0] = 1'b1;
					job.desel_long       = (mode_q == MODE_EE_WR);
					job.slots[SL_SELECT] = 1'b1;
					job.slots[SL_WREN]   = 1'b1;
					job.slots[SL_WDESEL] = 1'b1;
					job.slots[SL_WSEL]   = 1'b1;
					job.slots[SL_CMD]    = 1'b1;
					job.slots[SL_ADDR2]  = 1'b1;
					job.slots[SL_ADDR1]  = 1'b1;
					job.slots[SL_ADDR0]  = 1'b1;
				end
				enext_d = address + 24'd1;
				if (enext_d[EE_PAGE_BITS-1:0] == '0) begin
					job.slots[SL_PAGE] = 1'b1;
					mode_d             = MODE_NONE;
				end else begin
					mode_d = MODE_EE_WR;
				end
			end
			OP_FLUSH: begin
				if (mode_q == MODE_EE_WR) begin
					job.slots[SL_DESEL0] = 1'b1;
					job.desel_long       = 1'b1;
					mode_d               = MODE_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign push = accept && (job.slots != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			snext_q <= '0;
			enext_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			snext_q <= snext_d;
			enext_q <= enext_d;
		end
	end

endmodule

// ===== design/smas_queue.sv =====
module smas_queue
	import smas_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  smas_job_t    push_job,
	input  logic         pop,
	output smas_job_t    head,
	output smas_q_stat_t stat
);

	smas_job_t          entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign head           = entry_q[rd_ptr_q];
	assign stat.not_empty = (count_q != '0);
	assign stat.full      = (count_q == (Q_PTR_W+1)'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/smas_back.sv =====
module smas_back
	import smas_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  smas_job_t       head,
	input  smas_q_stat_t    q_stat,
	output logic            pop,
	output smas_back_stat_t stat,
	output logic            m_valid,
	input  logic            m_ready,
	output logic [2:0]      m_action,
	output logic            m_device,
	output logic [7:0]      m_byte,
	output logic            m_last
);

	logic [NUM_SLOTS-1:0] rem_q, low, rest;
	smas_job_t            cur_q;
	logic [SLOT_W-1:0]    idx;
	logic                 busy, advance;
	logic                 valid_q;
	smas_act_t            act;
	logic                 dev;
	logic [7:0]           byte_val;

	assign busy    = (rem_q != '0);
	assign low     = rem_q & (~rem_q + 1'b1);
	assign rest    = rem_q & ~low;
	assign advance = busy && (!valid_q || m_ready);
	assign pop     = q_stat.not_empty && (!busy || (advance && rest == '0));
	assign stat.busy = busy;

	always_comb begin
		idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		act      = ACT_SEND;
		dev      = 1'b0;
		byte_val = 8'd0;
		case (idx)
			SL_DESEL0: act = cur_q.desel_long ? ACT_DESEL_LONG : ACT_DESEL_SHORT;
			SL_DESEL1: act = ACT_DESEL_SHORT;
			SL_SELECT: begin
				act = ACT_SELECT;
				dev = cur_q.device;
			end
			SL_WREN:   byte_val = CMD_WREN;
			SL_WDESEL: act = ACT_DESEL_SHORT;
			SL_WSEL: begin
				act = ACT_SELECT;
				dev = 1'b1;
			end
			SL_CMD:    byte_val = cur_q.cmd;
			SL_ADDR2:  byte_val = cur_q.address[23:16];
			SL_ADDR1:  byte_val = cur_q.address[15:8];
			SL_ADDR0:  byte_val = cur_q.address[7:0];
			SL_DATA: begin
				if (cur_q.receive) begin
					act      = ACT_RECV;
					byte_val = RECV_FILL;
				end else begin
					byte_val = cur_q.write_data;
				end
			end
			SL_PAGE:   act = ACT_DESEL_LONG;
			default:   act = ACT_DESEL_SHORT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (advance) begin
			m_action <= act;
			m_device <= dev;
			m_byte   <= byte_val;
			m_last   <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rem_q <= head.slots;
			end else if (advance) begin
				rem_q <= rest;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (m_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_valid = valid_q;

endmodule

// ===== design/spi_memory_access_sequencer.sv =====
// An item reaches the master side through the queue entry, the job load in the back and then
// the output register.
// The front takes one item per cycle while its four-entry queue has room; the back emits one beat per
// cycle, one per action, unless the master side stalls; an item holds 1 to 11 actions.
// Reset (arst_n low): bus mode returns to no device selected, both next addresses clear, and
// the queue and the output register empty.
module spi_memory_access_sequencer
	import smas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [23:0] address, [31:24] write_data
	input  logic [2:0]  s_tuser,  // [2:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] byte_value
	output logic [3:0]  m_tuser,  // [2:0] action, [3] device
	output logic        m_tlast   // last
);

	smas_job_t       job, head;
	logic            push, pop, accept;
	smas_q_stat_t    q_stat;
	smas_back_stat_t b_stat;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	smas_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (s_tuser),
		.address    (s_tdata[23:0]),
		.write_data (s_tdata[31:24]),
		.job        (job),
		.push       (push)
	);

	smas_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	smas_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.stat     (b_stat),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_action (m_tuser[2:0]),
		.m_device (m_tuser[3]),
		.m_byte   (m_tdata),
		.m_last   (m_tlast)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty)
		else $error("queue read while empty");

	a_drain_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!b_stat.busy && !q_stat.not_empty && m_tvalid && m_tready) |=> !m_tvalid)
		else $error("beat shown with no work pending");

endmodule
